>>> hdl/dqsp_pkg.sv
package dqsp_pkg;

  // Field and state widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RunW     = 16;
  localparam int unsigned TimerW   = 17;
  localparam int unsigned SumW     = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounceCount  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInvertOutputs  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLongPulse      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBasePulseTicks = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgExtraPulseTicks = 3'd4;

  // Configuration reset values
  localparam logic [15:0] DebounceCountRst   = 16'd10;
  localparam logic        InvertOutputsRst   = 1'b0;
  localparam logic        LongPulseRst       = 1'b0;
  localparam logic [15:0] BasePulseTicksRst  = 16'd4;
  localparam logic [15:0] ExtraPulseTicksRst = 16'd36;

  // Judgment happens every fourth step; the sum must exceed the threshold in magnitude
  localparam logic signed [SumW-1:0] JudgeThreshold = 5'sd3;

  typedef struct packed {
    logic [15:0] debounce_count;
    logic        invert_outputs;
    logic        long_pulse;
    logic [15:0] base_pulse_ticks;
    logic [15:0] extra_pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic up_level;
    logic down_level;
    logic error_flag;
    logic busy_res;
  } res_t;

  // Quadrature step delta, indexed by {old A, old B, new A, new B}
  function automatic logic signed [2:0] quad_delta(input logic [3:0] idx);
    logic signed [2:0] d;
    case (idx) inside
      4'd1, 4'd7, 4'd8, 4'd14:  d = -3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 3'sd1;
      4'd3, 4'd6, 4'd9, 4'd12:  d = 3'sd2;
      default:                  d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/dqsp_cfg.sv
module dqsp_cfg
  import dqsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Decode the index and write the selected register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count    <= DebounceCountRst;
      cfg_q.invert_outputs    <= InvertOutputsRst;
      cfg_q.long_pulse        <= LongPulseRst;
      cfg_q.base_pulse_ticks  <= BasePulseTicksRst;
      cfg_q.extra_pulse_ticks <= ExtraPulseTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounceCount:   cfg_q.debounce_count    <= cfg_data_i;
        CfgInvertOutputs:   cfg_q.invert_outputs    <= cfg_data_i[0];
        CfgLongPulse:       cfg_q.long_pulse        <= cfg_data_i[0];
        CfgBasePulseTicks:  cfg_q.base_pulse_ticks  <= cfg_data_i;
        CfgExtraPulseTicks: cfg_q.extra_pulse_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/dqsp_core.sv
module dqsp_core
  import dqsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic line_a_i,
  input  logic line_b_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  typedef enum logic [1:0] {PhStartup, PhIdle, PhDebounce, PhHold} phase_e;
  typedef enum logic [1:0] {DirNone, DirUp, DirDown} dir_e;

  phase_e                 phase_q, phase_d;
  dir_e                   dir_q, dir_d;
  logic [1:0]             acc_q, acc_d;
  logic [1:0]             last_q, last_d;
  logic [RunW-1:0]        run_a_q, run_a_d;
  logic [RunW-1:0]        run_b_q, run_b_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [TimerW-1:0]      timer_q, timer_d;

  logic [1:0]             smp;
  logic [RunW-1:0]        need;
  logic                   finish;
  logic                   busy;
  logic                   err;
  dir_e                   act;
  dir_e                   judged;
  logic signed [2:0]      delta;
  logic signed [SumW-1:0] sum_new;
  logic [TimerW-1:0]      len;

  assign smp  = {line_a_i, line_b_i};
  assign need = (cfg_i.debounce_count == '0) ? RunW'(1) : cfg_i.debounce_count;

  // Step delta and pulse length
  assign delta   = quad_delta({acc_q, smp});
  assign sum_new = sum_q + {{(SumW-3){delta[2]}}, delta};
  assign len     = {1'b0, cfg_i.base_pulse_ticks}
                 + (cfg_i.long_pulse ? {1'b0, cfg_i.extra_pulse_ticks} : '0);

  always_comb begin
    phase_d = phase_q;
    dir_d   = dir_q;
    acc_d   = acc_q;
    last_d  = last_q;
    run_a_d = run_a_q;
    run_b_d = run_b_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    timer_d = timer_q;
    finish  = 1'b0;
    busy    = 1'b0;
    err     = 1'b0;
    act     = DirNone;
    judged  = DirNone;

    unique case (phase_q)
      PhStartup: begin
        acc_d   = smp;
        last_d  = smp;
        phase_d = PhIdle;
      end
      PhIdle: begin
        // A change opens a debounce; the changed sample is its first sample
        if (smp != acc_q) begin
          busy    = 1'b1;
          run_a_d = RunW'(1);
          run_b_d = RunW'(1);
          last_d  = smp;
          phase_d = PhDebounce;
          finish  = (need == RunW'(1));
        end
      end
      PhDebounce: begin
        busy = 1'b1;
        if (last_q[1] != smp[1]) begin
          run_a_d = RunW'(1);
        end else if (run_a_q != '1) begin
          run_a_d = run_a_q + RunW'(1);
        end
        if (last_q[0] != smp[0]) begin
          run_b_d = RunW'(1);
        end else if (run_b_q != '1) begin
          run_b_d = run_b_q + RunW'(1);
        end
        last_d = smp;
        finish = (run_a_d >= need) && (run_b_d >= need);
      end
      PhHold: begin
        // Drive the held pulse and count down
        busy    = 1'b1;
        act     = dir_q;
        timer_d = timer_q - TimerW'(1);
        if (timer_d == '0) begin
          phase_d = PhIdle;
          dir_d   = DirNone;
        end
      end
      default: ;
    endcase

    // Accept the debounced state, count the step, judge every fourth step
    if (finish) begin
      acc_d = smp;
      cnt_d = cnt_q + 2'd1;
      if (cnt_d != 2'd0) begin
        sum_d   = sum_new;
        phase_d = PhIdle;
      end else begin
        if (sum_new > JudgeThreshold) begin
          judged = DirUp;
        end else if (sum_new < -JudgeThreshold) begin
          judged = DirDown;
        end else begin
          err = 1'b1;
        end
        act     = judged;
        sum_d   = '0;
        timer_d = (len == '0) ? '0 : len - TimerW'(1);
        if (timer_d != '0) begin
          phase_d = PhHold;
          dir_d   = judged;
        end else begin
          phase_d = PhIdle;
          dir_d   = DirNone;
        end
      end
    end
  end

  // Hold state; advance once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStartup;
      dir_q   <= DirNone;
      acc_q   <= '0;
      last_q  <= '0;
      run_a_q <= '0;
      run_b_q <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      timer_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      dir_q   <= dir_d;
      acc_q   <= acc_d;
      last_q  <= last_d;
      run_a_q <= run_a_d;
      run_b_q <= run_b_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      timer_q <= timer_d;
    end
  end

  // Output levels follow the invert setting
  assign res_o.up_level   = (act == DirUp) ^ cfg_i.invert_outputs;
  assign res_o.down_level = (act == DirDown) ^ cfg_i.invert_outputs;
  assign res_o.error_flag = err;
  assign res_o.busy_res   = busy;

endmodule

>>> hdl/debounced_quadrature_step_pulser.sv
// Quadrature encoder decoder with debounce. Each accepted word is one sample
// of encoder lines A and B and yields exactly one result word: the up and down
// pin levels, a one-tick error flag and a busy flag. A line change is
// debounced until both lines have held steady for debounce_count samples; the
// step delta is then summed, and every fourth step the sum is judged into an
// up pulse, a down pulse or an error, held for base_pulse_ticks (plus
// extra_pulse_ticks when long_pulse is set). The block takes one word per
// clock cycle while the result register is free or drains; results come from
// the result register, the decoder state being updated in the single pass
// from the input register. The user must write registers through
// cfg_we_i/cfg_idx_i/cfg_data_i while no word is in flight; the block does not enforce it.
module debounced_quadrature_step_pulser
  import dqsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                line_a_i,
  input  logic                line_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                up_level_o,
  output logic                down_level_o,
  output logic                error_flag_o,
  output logic                busy_res_o
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic in_vld_q;
  logic in_a_q;
  logic in_b_q;
  logic out_vld_q;
  logic advance;

  dqsp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dqsp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .line_a_i (in_a_q),
    .line_b_i (in_b_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Move a word into the result register when that register is free or drains
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_a_q <= line_a_i;
      in_b_q <= line_b_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign up_level_o   = res_q.up_level;
  assign down_level_o = res_q.down_level;
  assign error_flag_o = res_q.error_flag;
  assign busy_res_o   = res_q.busy_res;

endmodule
